>>> sv/assert_macros.svh
// Assertion macros shared by the plane association RTL.
// Needs nothing else; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/pma_pkg.sv
// Shared types and constants of the plane map association block.
// No dependencies; used by every module of the block.
package pma_pkg;

  localparam int MAX_PLANES_DEF = 64;

  localparam int NORM_W    = 16;  // Q2.14
  localparam int OFF_W     = 32;  // Q16.16
  localparam int PROD_W    = 2 * NORM_W;
  localparam int DOT_W     = PROD_W + 1;  // sum of three products, Q5.28
  localparam int FRAC_W    = 14;
  localparam int COS_W     = 15;
  localparam int DIST_W    = 31;
  localparam int OUT_IDX_W = 6;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;

  localparam logic [DIST_W-1:0] DIST_RST     = DIST_W'(6554);
  localparam logic [COS_W-1:0]  SAME_COS_RST = COS_W'(14746);
  localparam logic [COS_W-1:0]  VERT_RST     = COS_W'(1311);
  localparam logic [COS_W-1:0]  PAR_RST      = COS_W'(14746);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_ASSOC  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] REG_DIST     = 2'd0;
  localparam logic [1:0] REG_SAME_COS = 2'd1;
  localparam logic [1:0] REG_VERT     = 2'd2;
  localparam logic [1:0] REG_PAR      = 2'd3;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic signed [OFF_W-1:0]  off;
  } plane_t;

  typedef struct packed {
    logic mul_en;    // register a*b
    logic acc_load;  // acc = product
    logic acc_add;   // acc += product
  } dot_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_MX,
    S_MY,
    S_MZ,
    S_SUM,
    S_TEST,
    S_FINISH,
    S_DONE
  } state_t;

endpackage

>>> sv/plane_map_association_top.sv
// Plane map association top: APB registers, sequencer and scan compare logic.
// Depends on pma_pkg, pma_table, pma_dot and assert_macros.svh.
// Add, clear and unused op give done in the cycle after the accept edge.
// Associate: each table entry scanned takes a memory read, three passes of the
//   shared multiplier, sum, test; up to MAX_PLANES entries; then finish, done.
// busy is high from the cycle after accept through done; done lasts one cycle.
// Sync reset loads threshold defaults, clears count, frame flag; table data kept.
`include "assert_macros.svh"
module plane_map_association_top #(
  parameter int MAX_PLANES = pma_pkg::MAX_PLANES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pma_pkg::ADDR_W-1:0]            paddr,
  input  logic [pma_pkg::DATA_W-1:0]            pwdata,
  output logic [pma_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            op,
  input  logic signed [pma_pkg::NORM_W-1:0]     normal_x,
  input  logic signed [pma_pkg::NORM_W-1:0]     normal_y,
  input  logic signed [pma_pkg::NORM_W-1:0]     normal_z,
  input  logic signed [pma_pkg::OFF_W-1:0]      plane_offset,
  input  logic                                  frame_last,
  output logic                                  done,
  output logic                                  status,
  output logic                                  match_found,
  output logic [pma_pkg::OUT_IDX_W-1:0]         match_index,
  output logic                                  vertical_found,
  output logic [pma_pkg::OUT_IDX_W-1:0]         vertical_index,
  output logic                                  parallel_found,
  output logic [pma_pkg::OUT_IDX_W-1:0]         parallel_index,
  output logic                                  frame_new_plane
);
  import pma_pkg::*;

  localparam int IDX_W   = $clog2(MAX_PLANES);
  localparam int CNT_W   = $clog2(MAX_PLANES + 1);
  localparam int THR_PAD = DOT_W - COS_W - FRAC_W;
  localparam int DST_PAD = DOT_W - DIST_W;

  function automatic logic [OUT_IDX_W-1:0] idx_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

  // configuration registers
  logic [DIST_W-1:0] dist_threshold;
  logic [COS_W-1:0]  same_cos_threshold;
  logic [COS_W-1:0]  vertical_threshold;
  logic [COS_W-1:0]  parallel_threshold;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_threshold     <= DIST_RST;
      same_cos_threshold <= SAME_COS_RST;
      vertical_threshold <= VERT_RST;
      parallel_threshold <= PAR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DIST:     dist_threshold     <= pwdata[DIST_W-1:0];
        REG_SAME_COS: same_cos_threshold <= pwdata[COS_W-1:0];
        REG_VERT:     vertical_threshold <= pwdata[COS_W-1:0];
        REG_PAR:      parallel_threshold <= pwdata[COS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIST:     prdata = DATA_W'(dist_threshold);
      REG_SAME_COS: prdata = DATA_W'(same_cos_threshold);
      REG_VERT:     prdata = DATA_W'(vertical_threshold);
      REG_PAR:      prdata = DATA_W'(parallel_threshold);
    endcase
  end

  // control and scan state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic               seen;
  logic [IDX_W-1:0]   j;
  logic [CNT_W-1:0]   j_inc;
  logic               accept;
  logic               full;
  plane_t             obs;
  logic               obs_last;
  plane_t             ent;
  logic signed [DOT_W-1:0] diff;
  logic signed [DOT_W-1:0] acc;
  logic [DOT_W-1:0]   ac;
  logic [DOT_W-1:0]   e_abs;
  logic               same_hit, vert_hit, par_hit, scan_end;
  dot_ctrl_t          dot_ctrl;
  logic signed [NORM_W-1:0] dot_a, dot_b;
  logic               rd_en;
  plane_t             in_word;

  assign accept  = start & ~busy;
  assign full    = (count == CNT_W'(MAX_PLANES));
  assign j_inc   = CNT_W'(j) + CNT_W'(1);
  assign in_word = '{nx: normal_x, ny: normal_y, nz: normal_z, off: plane_offset};

  pma_table #(.DEPTH(MAX_PLANES)) u_table (
    .clk     (clk),
    .wr_en   (accept && op == OP_ADD && !full),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (in_word),
    .rd_en   (rd_en),
    .rd_addr (j),
    .rd_data (ent)
  );

  pma_dot u_dot (
    .clk  (clk),
    .ctrl (dot_ctrl),
    .a    (dot_a),
    .b    (dot_b),
    .acc  (acc)
  );

  // scan tests; the first passing test claims the entry
  assign ac    = acc[DOT_W-1] ? DOT_W'(-acc) : DOT_W'(acc);
  assign e_abs = diff[DOT_W-1] ? DOT_W'(-diff) : DOT_W'(diff);

  assign same_hit = !match_found
                    && ac > {{THR_PAD{1'b0}}, same_cos_threshold, {FRAC_W{1'b0}}}
                    && e_abs < {{DST_PAD{1'b0}}, dist_threshold};
  assign vert_hit = !same_hit && !vertical_found
                    && ac < {{THR_PAD{1'b0}}, vertical_threshold, {FRAC_W{1'b0}}};
  assign par_hit  = !same_hit && !vert_hit && !parallel_found
                    && ac > {{THR_PAD{1'b0}}, parallel_threshold, {FRAC_W{1'b0}}};
  assign scan_end = ((match_found | same_hit) & (vertical_found | vert_hit)
                     & (parallel_found | par_hit)) | (j_inc >= count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_ASSOC) begin
            state_next = (count == '0) ? S_FINISH : S_FETCH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FETCH:  state_next = S_MX;
      S_MX:     state_next = S_MY;
      S_MY:     state_next = S_MZ;
      S_MZ:     state_next = S_SUM;
      S_SUM:    state_next = S_TEST;
      S_TEST:   state_next = scan_end ? S_FINISH : S_FETCH;
      S_FINISH: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != S_IDLE);
    done     = (state == S_DONE);
    rd_en    = (state == S_FETCH);
    dot_ctrl = '0;
    dot_a    = '0;
    dot_b    = '0;
    unique case (state)
      S_MX: begin
        dot_ctrl.mul_en = 1'b1;
        dot_a = obs.nx;
        dot_b = ent.nx;
      end
      S_MY: begin
        dot_ctrl.mul_en   = 1'b1;
        dot_ctrl.acc_load = 1'b1;
        dot_a = obs.ny;
        dot_b = ent.ny;
      end
      S_MZ: begin
        dot_ctrl.mul_en  = 1'b1;
        dot_ctrl.acc_add = 1'b1;
        dot_a = obs.nz;
        dot_b = ent.nz;
      end
      S_SUM:   dot_ctrl.acc_add = 1'b1;
      default: dot_ctrl = '0;
    endcase
  end

  // offset difference is taken while the first product is formed
  always_ff @(posedge clk) begin
    if (accept && op == OP_ASSOC) begin
      obs      <= in_word;
      obs_last <= frame_last;
    end
    if (state == S_MX) begin
      diff <= {obs.off[OFF_W-1], obs.off} - {ent.off[OFF_W-1], ent.off};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seen  <= 1'b0;
    end else begin
      if (accept && op == OP_ADD && !full) begin
        count <= count + CNT_W'(1);
      end else if (accept && op == OP_CLEAR) begin
        count <= '0;
      end
      if (state == S_FINISH) begin
        seen <= obs_last ? 1'b0 : (seen | ~match_found);
      end
    end
  end

  // result word, also used as the running scan flags
  always_ff @(posedge clk) begin
    if (accept) begin
      j               <= '0;
      status          <= (op == OP_ADD) && full;
      match_found     <= 1'b0;
      match_index     <= '0;
      vertical_found  <= 1'b0;
      vertical_index  <= '0;
      parallel_found  <= 1'b0;
      parallel_index  <= '0;
      frame_new_plane <= 1'b0;
    end else if (state == S_TEST) begin
      j <= j_inc[IDX_W-1:0];
      if (same_hit) begin
        match_found <= 1'b1;
        match_index <= idx_out(j);
      end
      if (vert_hit) begin
        vertical_found <= 1'b1;
        vertical_index <= idx_out(j);
      end
      if (par_hit) begin
        parallel_found <= 1'b1;
        parallel_index <= idx_out(j);
      end
    end else if (state == S_FINISH) begin
      frame_new_plane <= obs_last & (seen | ~match_found);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(MAX_PLANES), "count above depth")
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "done not a single pulse")
  `ASSERT_IMPLIES(a_scan_in_range, clk, rst, state == S_TEST, CNT_W'(j) < count,
                  "scan past table fill")
  `ASSERT_IMPLIES(a_idx_clean, clk, rst, done && !match_found, match_index == '0,
                  "index without match")
  `ASSERT_IMPLIES(a_status_add_only, clk, rst, done && status,
                  !match_found && !vertical_found && !parallel_found && !frame_new_plane,
                  "status with scan result")

endmodule

>>> sv/pma_table.sv
// Plane table memory: one write port, one registered read port.
// Depends on pma_pkg for the entry type.
module pma_table #(
  parameter int DEPTH = pma_pkg::MAX_PLANES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pma_pkg::plane_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output pma_pkg::plane_t rd_data
);
  import pma_pkg::*;

  plane_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/pma_dot.sv
// Shared multiply-accumulate unit: one 16x16 product a cycle into a 33-bit sum.
// Depends on pma_pkg for widths and the control word.
module pma_dot (
  input  logic                                clk,
  input  pma_pkg::dot_ctrl_t                  ctrl,
  input  logic signed [pma_pkg::NORM_W-1:0]   a,
  input  logic signed [pma_pkg::NORM_W-1:0]   b,
  output logic signed [pma_pkg::DOT_W-1:0]    acc
);
  import pma_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [DOT_W-1:0]  prod_ext;

  assign prod_ext = {prod[PROD_W-1], prod};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= a * b;
    end
    if (ctrl.acc_load) begin
      acc <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc <= acc + prod_ext;
    end
  end

endmodule
